// ===== design/ritoa_pkg.sv =====
`default_nettype none

package ritoa_pkg;

  // Quotient bits resolved per divider cycle
  localparam int unsigned QBITS = 8;

  localparam logic [4:0] RADIX_MIN = 5'd2;
  localparam logic [4:0] RADIX_MAX = 5'd16;

  localparam logic [7:0] CHAR_MINUS   = 8'h2d;  // '-'
  localparam logic [7:0] CHAR_ZERO    = 8'h30;  // '0'
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;  // 'a'
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;  // 'A'

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SIGN,
    ST_FETCH,
    ST_EMIT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;      // capture a new number
    logic step;      // run one divider cycle
    logic fetch;     // read the digit store at the current index
    logic dec;       // move to the next lower digit
    logic sel_sign;  // present '-' on the output
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic conv_done;  // last digit written this cycle
    logic negative;   // number carries a '-'
    logic idx_zero;   // current digit is the least significant one
  } sts_t;

  // Map one digit value to its ASCII character
  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic lower);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CHAR_ZERO + {4'd0, d};
    end else if (lower) begin
      c = CHAR_LOWER_A + {4'd0, d} - 8'd10;
    end else begin
      c = CHAR_UPPER_A + {4'd0, d} - 8'd10;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== design/ritoa_ctrl.sv =====
`default_nettype none

module ritoa_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  wire logic            out_stall,
  input  wire ritoa_pkg::sts_t sts,
  output ritoa_pkg::cmd_t      cmd
);

  ritoa_pkg::state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ritoa_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ritoa_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ritoa_pkg::ST_DIV;
        end
      end
      ritoa_pkg::ST_DIV: begin
        if (sts.conv_done) begin
          state_nxt = sts.negative ? ritoa_pkg::ST_SIGN : ritoa_pkg::ST_FETCH;
        end
      end
      ritoa_pkg::ST_SIGN: begin
        if (!out_stall) begin
          state_nxt = ritoa_pkg::ST_FETCH;
        end
      end
      ritoa_pkg::ST_FETCH: begin
        state_nxt = ritoa_pkg::ST_EMIT;
      end
      ritoa_pkg::ST_EMIT: begin
        if (!out_stall) begin
          state_nxt = sts.idx_zero ? ritoa_pkg::ST_IDLE : ritoa_pkg::ST_FETCH;
        end
      end
      default: begin
        state_nxt = ritoa_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs and datapath commands
  always_comb begin
    in_stall     = (state_r != ritoa_pkg::ST_IDLE);
    out_valid    = (state_r == ritoa_pkg::ST_SIGN) || (state_r == ritoa_pkg::ST_EMIT);
    cmd.load     = (state_r == ritoa_pkg::ST_IDLE) && in_valid;
    cmd.step     = (state_r == ritoa_pkg::ST_DIV);
    cmd.fetch    = (state_r == ritoa_pkg::ST_FETCH);
    cmd.dec      = (state_r == ritoa_pkg::ST_EMIT) && !out_stall && !sts.idx_zero;
    cmd.sel_sign = (state_r == ritoa_pkg::ST_SIGN);
  end

endmodule

`default_nettype wire

// ===== design/ritoa_dp.sv =====
`default_nettype none

module ritoa_dp #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic                   clk,
  input  wire logic [VALUE_WIDTH-1:0] in_value_bits,
  input  wire logic [4:0]             in_radix,
  input  wire logic                   in_lowercase,
  input  wire logic                   in_unsigned_mode,
  output logic [7:0]                  out_ascii_char,
  output logic                        out_last_char,
  input  wire ritoa_pkg::cmd_t        cmd,
  output ritoa_pkg::sts_t             sts
);

  localparam int unsigned STEPS = (VALUE_WIDTH + ritoa_pkg::QBITS - 1) / ritoa_pkg::QBITS;
  localparam int unsigned PW    = STEPS * ritoa_pkg::QBITS;
  localparam int unsigned SW    = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int unsigned AW    = $clog2(VALUE_WIDTH);

  // Digit store, least significant digit first
  logic [3:0] mem [VALUE_WIDTH];

  logic [PW-1:0] q_r;
  logic [3:0]    rem_r;
  logic [4:0]    radix_r;
  logic          lower_r;
  logic          neg_r;
  logic [SW-1:0] step_r;
  logic [AW-1:0] cnt_r;
  logic [AW-1:0] idx_r;
  logic [3:0]    rd_data_r;

  logic [ritoa_pkg::QBITS-1:0] chunk;
  logic [ritoa_pkg::QBITS-1:0] qbits;
  logic [4:0]                  r;
  logic [3:0]                  rem_nxt;
  logic [PW+ritoa_pkg::QBITS-1:0] q_cat;
  logic [PW-1:0]               q_nxt;
  logic                        last_step;
  logic                        digit_end;
  logic                        finish;

  logic                   in_neg;
  logic [VALUE_WIDTH-1:0] in_mag;
  logic [4:0]             radix_clamped;

  // Long division by the radix, eight quotient bits per cycle, MSB first
  always_comb begin
    chunk = q_r[PW-1 -: ritoa_pkg::QBITS];
    r     = {1'b0, rem_r};
    qbits = '0;
    for (int j = ritoa_pkg::QBITS - 1; j >= 0; j--) begin
      r = {r[3:0], chunk[j]};
      if (r >= radix_r) begin
        r        = r - radix_r;
        qbits[j] = 1'b1;
      end
    end
    rem_nxt = r[3:0];
    q_cat   = {q_r, qbits};
    q_nxt   = q_cat[PW-1:0];
  end

  assign last_step = (step_r == SW'(STEPS - 1));
  assign digit_end = cmd.step && last_step;
  assign finish    = (q_nxt == '0) || (cnt_r == AW'(VALUE_WIDTH - 1));

  // Input magnitude and radix saturation
  always_comb begin
    in_neg = !in_unsigned_mode && in_value_bits[VALUE_WIDTH-1];
    in_mag = in_neg ? (VALUE_WIDTH'(0) - in_value_bits) : in_value_bits;
    if (in_radix < ritoa_pkg::RADIX_MIN) begin
      radix_clamped = ritoa_pkg::RADIX_MIN;
    end else if (in_radix > ritoa_pkg::RADIX_MAX) begin
      radix_clamped = ritoa_pkg::RADIX_MAX;
    end else begin
      radix_clamped = in_radix;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      q_r     <= PW'(in_mag);
      rem_r   <= '0;
      radix_r <= radix_clamped;
      lower_r <= in_lowercase;
      neg_r   <= in_neg;
      step_r  <= '0;
      cnt_r   <= '0;
    end else if (cmd.step) begin
      q_r <= q_nxt;
      if (last_step) begin
        rem_r  <= '0;
        step_r <= '0;
        if (finish) begin
          idx_r <= cnt_r;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end else begin
        rem_r  <= rem_nxt;
        step_r <= step_r + 1'b1;
      end
    end else if (cmd.dec) begin
      idx_r <= idx_r - 1'b1;
    end
  end

  // Digit store write and registered read
  always_ff @(posedge clk) begin
    if (digit_end) begin
      mem[cnt_r] <= rem_nxt;
    end
    if (cmd.fetch) begin
      rd_data_r <= mem[idx_r];
    end
  end

  // Status and output character
  always_comb begin
    sts.conv_done  = digit_end && finish;
    sts.negative   = neg_r;
    sts.idx_zero   = (idx_r == '0);
    out_ascii_char = cmd.sel_sign ? ritoa_pkg::CHAR_MINUS
                                  : ritoa_pkg::digit_char(rd_data_r, lower_r);
    out_last_char  = !cmd.sel_sign && (idx_r == '0);
  end

endmodule

`default_nettype wire

// ===== design/radix_integer_to_ascii_top.sv =====
`default_nettype none

// Integer to ASCII converter. Each input beat carries one integer, a radix
// (2 to 16, saturated at both ends), a lowercase flag and an unsigned-mode
// flag; the block answers with one output beat per character, most
// significant first, a '-' first for a negative value in signed mode, and
// out_last_char set on the final digit. Only the low VALUE_WIDTH bits of
// in_value_bits are used. Digits come from a shared divider that resolves
// eight quotient bits per cycle, so each digit takes a pass over the whole
// quotient; each character is then read from the digit store and then
// presented, and the sign is presented straight away. One item is in flight
// at a time; in_stall stays high until its last beat is taken.
module radix_integer_to_ascii_top #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [VALUE_WIDTH-1:0] in_value_bits,
  input  wire logic [4:0]             in_radix,
  input  wire logic                   in_lowercase,
  input  wire logic                   in_unsigned_mode,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [7:0]                  out_ascii_char,
  output logic                        out_last_char
);

  ritoa_pkg::cmd_t cmd;
  ritoa_pkg::sts_t sts;

  ritoa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  ritoa_dp #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk              (clk),
    .in_value_bits    (in_value_bits),
    .in_radix         (in_radix),
    .in_lowercase     (in_lowercase),
    .in_unsigned_mode (in_unsigned_mode),
    .out_ascii_char   (out_ascii_char),
    .out_last_char    (out_last_char),
    .cmd              (cmd),
    .sts              (sts)
  );

endmodule

`default_nettype wire

// ===== dv/ritoa_char_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels of the integer-to-ASCII converter, builds the
// expected character beats for every accepted number and compares each
// accepted output beat with the oldest one still waiting.
module ritoa_char_checker #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  input  wire logic                   in_stall,
  input  wire logic [VALUE_WIDTH-1:0] in_value_bits,
  input  wire logic [4:0]             in_radix,
  input  wire logic                   in_lowercase,
  input  wire logic                   in_unsigned_mode,
  input  wire logic                   out_valid,
  input  wire logic                   out_stall,
  input  wire logic [7:0]             out_ascii_char,
  input  wire logic                   out_last_char,
  output int                          mismatch_count,
  output int                          chars_pending
);

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_beat_t;

  char_beat_t expected_chars[$];
  int         numbers_seen;
  int         chars_seen;

  always @(posedge clk) begin
    logic [VALUE_WIDTH-1:0] magnitude;
    logic [4:0]             base;
    logic [3:0]             digits [VALUE_WIDTH];
    logic [3:0]             d;
    logic                   negative;
    int                     n;
    int                     i;
    char_beat_t             want;
    char_beat_t             beat;

    if (!rst_n) begin
      expected_chars.delete();
      mismatch_count = 0;
      numbers_seen   = 0;
      chars_seen     = 0;
    end else begin
      // Compare an accepted output beat with the oldest expected character
      if (out_valid && !out_stall) begin
        chars_seen++;
        if (expected_chars.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT) begin
            $display("[%0t] unexpected char beat %0d: char %h last %0b", $realtime,
                     chars_seen, out_ascii_char, out_last_char);
          end
        end else begin
          want = expected_chars.pop_front();
          if (out_ascii_char !== want.ch || out_last_char !== want.last) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
              $display("[%0t] char beat %0d: expected char %h last %0b, got char %h last %0b",
                       $realtime, chars_seen, want.ch, want.last, out_ascii_char,
                       out_last_char);
            end
          end
        end
      end

      // Predict the characters of an accepted number
      if (in_valid && !in_stall) begin
        numbers_seen++;
        if (in_radix < ritoa_pkg::RADIX_MIN) begin
          base = ritoa_pkg::RADIX_MIN;
        end else if (in_radix > ritoa_pkg::RADIX_MAX) begin
          base = ritoa_pkg::RADIX_MAX;
        end else begin
          base = in_radix;
        end
        negative  = !in_unsigned_mode && in_value_bits[VALUE_WIDTH-1];
        magnitude = negative ? (~in_value_bits + 1'b1) : in_value_bits;

        // Peel digits off the least significant end
        n = 0;
        do begin
          digits[n] = 4'(magnitude % base);
          n++;
          magnitude = magnitude / base;
        end while (magnitude != 0 && n < VALUE_WIDTH);

        if (negative) begin
          beat.ch   = ritoa_pkg::CHAR_MINUS;
          beat.last = 1'b0;
          expected_chars.push_back(beat);
        end
        // Queue digits most significant first, mark the final one
        for (i = n - 1; i >= 0; i--) begin
          d = digits[i];
          if (d < 4'd10) begin
            beat.ch = ritoa_pkg::CHAR_ZERO + 8'(d);
          end else begin
            beat.ch = (in_lowercase ? ritoa_pkg::CHAR_LOWER_A : ritoa_pkg::CHAR_UPPER_A)
                      + 8'(d) - 8'd10;
          end
          beat.last = (i == 0);
          expected_chars.push_back(beat);
        end
      end
    end
    chars_pending = expected_chars.size();
  end

endmodule

// ===== dv/radix_integer_to_ascii_top_test.sv =====
`timescale 1ns / 1ps

module radix_integer_to_ascii_top_test;

  localparam int unsigned VW             = 32;
  localparam int          RANDOM_NUMBERS = 248;
  localparam int          HOLD_OFF_BEATS = 300;
  localparam int          DRAIN_CYCLES   = 60;

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_stall;
  logic [VW-1:0] in_value_bits;
  logic [4:0]    in_radix;
  logic          in_lowercase;
  logic          in_unsigned_mode;
  logic          out_valid;
  logic          out_stall;
  logic [7:0]    out_ascii_char;
  logic          out_last_char;

  int mismatch_count;
  int chars_pending;
  bit calm;
  bit hold_off_req;

  radix_integer_to_ascii_top #(
    .VALUE_WIDTH(VW)
  ) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_value_bits   (in_value_bits),
    .in_radix        (in_radix),
    .in_lowercase    (in_lowercase),
    .in_unsigned_mode(in_unsigned_mode),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_ascii_char  (out_ascii_char),
    .out_last_char   (out_last_char)
  );

  ritoa_char_checker #(
    .VALUE_WIDTH(VW)
  ) i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_value_bits   (in_value_bits),
    .in_radix        (in_radix),
    .in_lowercase    (in_lowercase),
    .in_unsigned_mode(in_unsigned_mode),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_ascii_char  (out_ascii_char),
    .out_last_char   (out_last_char),
    .mismatch_count  (mismatch_count),
    .chars_pending   (chars_pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Offer one number at a falling edge, hold it until the block takes it
  task automatic offer_number(input logic [VW-1:0] value, input logic [4:0] radix,
                              input logic lower, input logic uns);
    while (!calm && $urandom_range(99) < 37) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_value_bits    <= value;
    in_radix         <= radix;
    in_lowercase     <= lower;
    in_unsigned_mode <= uns;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Receiver: random stalls, a quiet stretch, and one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_BEATS) @(negedge clk);
      end else if (calm) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 37);
      end
    end
  end

  // Stimulus and verdict
  initial begin
    logic [VW-1:0] value;
    logic [4:0]    radix;
    int            k;

    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_value_bits    = '0;
    in_radix         = ritoa_pkg::RADIX_MIN;
    in_lowercase     = 1'b0;
    in_unsigned_mode = 1'b0;
    calm             = 1'b0;
    hold_off_req     = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: extremes, both letter cases, both modes, radix saturation
    offer_number(32'd0,          5'd10, 1'b0, 1'b0);
    offer_number(32'd0,          5'd2,  1'b1, 1'b1);
    offer_number(32'h7fffffff,   5'd10, 1'b0, 1'b0);
    offer_number(32'h80000000,   5'd10, 1'b0, 1'b0);
    offer_number(32'h80000000,   5'd2,  1'b0, 1'b0);
    offer_number(32'hffffffff,   5'd2,  1'b0, 1'b1);
    offer_number(32'hffffffff,   5'd16, 1'b0, 1'b1);
    offer_number(32'hffffffff,   5'd10, 1'b1, 1'b0);
    offer_number(32'hdeadbeef,   5'd16, 1'b1, 1'b1);
    offer_number(32'hdeadbeef,   5'd16, 1'b0, 1'b0);
    offer_number(32'h0000abcf,   5'd16, 1'b1, 1'b0);
    offer_number(32'h0000abcf,   5'd16, 1'b0, 1'b0);
    offer_number(32'd5,          5'd0,  1'b0, 1'b0);
    offer_number(32'd6,          5'd1,  1'b0, 1'b1);
    offer_number(32'd255,        5'd17, 1'b1, 1'b1);
    offer_number(32'h12345678,   5'd31, 1'b0, 1'b1);
    offer_number(32'hfffffff1,   5'd3,  1'b0, 1'b0);
    offer_number(32'd1234567890, 5'd7,  1'b0, 1'b1);
    offer_number(32'd4095,       5'd8,  1'b0, 1'b1);
    offer_number(32'd3374,       5'd15, 1'b1, 1'b1);
    offer_number(32'd15,         5'd16, 1'b1, 1'b0);
    offer_number(32'd1,          5'd9,  1'b1, 1'b0);

    // Random numbers with a hold-off, a quiet stretch and one full drain
    for (k = 0; k < RANDOM_NUMBERS; k++) begin
      if (k == 40) hold_off_req = 1'b1;
      calm = (k >= 90 && k < 140);
      if (k == 180) begin
        in_valid <= 1'b0;
        do @(negedge clk); while (chars_pending != 0);
      end
      case ($urandom_range(5))
        0: value = $urandom();
        1: value = $urandom_range(255);
        2: value = $urandom_range(65535);
        3: value = 32'h80000000 | $urandom_range(255);
        4: value = -$urandom_range(1000);
        default: value = $urandom() >> $urandom_range(31);
      endcase
      if ($urandom_range(9) == 0) begin
        radix = 5'($urandom_range(31));
      end else begin
        radix = 5'($urandom_range(16, 2));
      end
      offer_number(value, radix, 1'($urandom_range(1)), 1'($urandom_range(1)));
    end

    // Drain and let the tail settle
    in_valid <= 1'b0;
    do @(negedge clk); while (chars_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && chars_pending == 0) begin
      $display("radix_integer_to_ascii_top verification clean");
    end else begin
      $display("radix_integer_to_ascii_top verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5ms;
    $display("radix_integer_to_ascii_top verification failed");
    $finish;
  end

endmodule
